[rtl/core/axis_angle_vector_rotation_defines.svh]
// assertion macros used by the rotation block checker
`ifndef AXIS_ANGLE_VECTOR_ROTATION_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define AAVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define AAVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/aavr_pkg.sv]
// types, constants and tables of the axis-angle rotation block
`timescale 1ns / 1ps
package aavr_pkg;

  localparam int FIELD_W       = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_BITS_DEF = 32;

  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int CORDIC_STEPS = 30;

  localparam int SUM_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 34;
  localparam int QUO_W  = 31;
  localparam int XY_W   = 34;
  localparam int Z_W    = 33;

  localparam logic [63:0] TURN_C      = 64'h28BE_60DB_9391_054A;
  localparam logic [31:0] CORDIC_GAIN = 32'h26DD_3B6A;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef struct packed {
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
    logic signed [FIELD_W-1:0] axis_angle_x;
    logic signed [FIELD_W-1:0] axis_angle_y;
    logic signed [FIELD_W-1:0] axis_angle_z;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] rot_x;
    logic signed [FIELD_W-1:0] rot_y;
    logic signed [FIELD_W-1:0] rot_z;
    logic                      overflow;
  } out_t;

  // one digit pair of the square root
  typedef struct packed {
    logic [SUM_W-1:0]  s;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // one quotient bit of an axis component
  typedef struct packed {
    logic [ROOT_W-1:0] dvs;
    logic [ROOT_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
    logic [QUO_W-1:0]  nb;
  } div_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } cordic_t;

  // data that rides alongside the arithmetic chains
  typedef struct packed {
    logic [2:0][FIELD_W-1:0] v;
    logic [2:0][FIELD_W-1:0] aw;
    logic [2:0]              wneg;
    logic                    zero;
  } side_t;

endpackage

[rtl/core/aavr_stream_if.sv]
// valid/ready stream channel carrying one payload item per transfer
`timescale 1ns / 1ps
interface aavr_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/aavr_sqrt_cell.sv]
// one restoring square root cell, two radicand bits per cell
`timescale 1ns / 1ps
module aavr_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  aavr_pkg::sqrt_t d_i,
  output aavr_pkg::sqrt_t q_o
);
  import aavr_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;
  sqrt_t            q_d;
  sqrt_t            q_q;

  always_comb begin
    rem_sh    = {d_i.rem, d_i.s[SUM_W-1 -: 2]};
    trial     = {2'b00, d_i.root, 2'b01};
    diff      = rem_sh - trial;
    ge        = (rem_sh >= trial);
    q_d.s     = {d_i.s[SUM_W-3:0], 2'b00};
    q_d.rem   = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    q_d.root  = {d_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

[rtl/core/aavr_div_cell.sv]
// one restoring divider cell, one quotient bit per cell
`timescale 1ns / 1ps
module aavr_div_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  aavr_pkg::div_t d_i,
  output aavr_pkg::div_t q_o
);
  import aavr_pkg::*;

  logic [ROOT_W:0] rem_sh;
  logic [ROOT_W:0] diff;
  logic            ge;
  div_t            q_d;
  div_t            q_q;

  always_comb begin
    rem_sh  = {d_i.rem, d_i.nb[QUO_W-1]};
    diff    = rem_sh - {1'b0, d_i.dvs};
    ge      = (rem_sh >= {1'b0, d_i.dvs});
    q_d.dvs = d_i.dvs;
    q_d.rem = ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
    q_d.quo = {d_i.quo[QUO_W-2:0], ge};
    q_d.nb  = {d_i.nb[QUO_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

[rtl/core/aavr_cordic_cell.sv]
// one rotation-mode cordic micro-rotation
`timescale 1ns / 1ps
module aavr_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  aavr_pkg::cordic_t d_i,
  output aavr_pkg::cordic_t q_o
);
  import aavr_pkg::*;

  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  logic signed [Z_W-1:0]  at;
  cordic_t                q_d;
  cordic_t                q_q;

  always_comb begin
    x_sh     = d_i.x >>> STEP;
    y_sh     = d_i.y >>> STEP;
    at       = $signed(Z_W'(ATAN_TURNS[STEP]));
    q_d.flip = d_i.flip;
    if (!d_i.z[Z_W-1]) begin
      q_d.x = d_i.x - y_sh;
      q_d.y = d_i.y + x_sh;
      q_d.z = d_i.z - at;
    end else begin
      q_d.x = d_i.x + y_sh;
      q_d.y = d_i.y - x_sh;
      q_d.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;
endmodule

[rtl/core/axis_angle_vector_rotation.sv]
// rodrigues rotation of a q16.16 vector about an axis-angle vector
// channels: in_i takes vec_x/y/z and axis_angle_x/y/z, out_o gives rot_x/y/z and
//   overflow; a transfer happens at a rising edge with valid and ready high
// throughput: one item per cycle while the skid entry is free and in_i.ready is high;
//   every stage is a register, nothing iterates in place
//   square root: 32 cells, axis divide: 31 cells per component, cordic: 30 cells
// a zero rotation vector passes the input through, saturated to WORD_BITS
// reset: clears the valid chain and the output buffer, datapath registers keep junk
// stall: the output register plus one skid entry absorb a stalled receiver; the
//   chain keeps accepting until the skid entry fills, then in_i.ready drops
//   and every stage holds until out_o.ready returns
// FRAC_BITS sets the angle scale of the phase slice, WORD_BITS the saturation range
`timescale 1ns / 1ps
module axis_angle_vector_rotation #(
  parameter int FRAC_BITS = aavr_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = aavr_pkg::WORD_BITS_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  aavr_stream_if.sink   in_i,
  aavr_stream_if.source out_o
);
  import aavr_pkg::*;

  // stage map: 1 squares, 2 sum, 3..34 root, 35..66 divide and sin/cos,
  // 67..71 product terms, output register after that
  localparam int SQRT_END = 2 + SQRT_STEPS;
  localparam int MID_END  = SQRT_END + DIV_STEPS + 1;
  localparam int LAST     = MID_END + 5;
  localparam int PH_LSB   = 32 + FRAC_BITS;
  localparam int RW       = 66;
  localparam logic [29:0]   RND     = 30'h2000_0000;
  localparam logic [RW-1:0] SAT_MAX = {{(RW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic [RW-1:0] SAT_MIN = ~SAT_MAX;

  logic en;
  logic out_v_q, skid_v_q;
  out_t out_data_q, skid_data_q;

  // the whole chain moves together while the skid entry is free
  assign en         = !skid_v_q;
  assign in_i.ready = en;

  // input side
  in_t                din;
  logic signed [31:0] w_in [3];
  side_t              side_in;

  always_comb begin
    din     = in_i.data;
    w_in[0] = din.axis_angle_x;
    w_in[1] = din.axis_angle_y;
    w_in[2] = din.axis_angle_z;
    side_in.v[0] = din.vec_x;
    side_in.v[1] = din.vec_y;
    side_in.v[2] = din.vec_z;
    for (int i = 0; i < 3; i++) begin
      side_in.wneg[i] = w_in[i][31];
      side_in.aw[i]   = w_in[i][31] ? (32'd0 - w_in[i]) : w_in[i];
    end
    side_in.zero = (w_in[0] == 32'sd0) && (w_in[1] == 32'sd0) && (w_in[2] == 32'sd0);
  end

  // valid and side shift lines
  logic [LAST:1] vld_q;
  side_t         side_q [1:LAST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:1], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side_in;
      for (int k = 2; k <= LAST; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // squared length of the rotation vector
  logic [SUM_W-1:0] sq_q [3];
  logic [SUM_W-1:0] s_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= w_in[i] * w_in[i];
      end
      s_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  // floor square root, one result bit per cell
  sqrt_t sq_init;
  sqrt_t sqc [SQRT_STEPS];

  always_comb begin
    sq_init.s    = s_q;
    sq_init.rem  = '0;
    sq_init.root = '0;
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    if (j == 0) begin : g_first
      aavr_sqrt_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(sq_init), .q_o(sqc[j]));
    end else begin : g_next
      aavr_sqrt_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(sqc[j-1]), .q_o(sqc[j]));
    end
  end

  logic [ROOT_W-1:0] root;
  assign root = sqc[SQRT_STEPS-1].root;

  // unit axis: |w| * 2^30 / magnitude, the top quotient bits are known zero
  div_t             dv_init [3];
  div_t             dvc [3][DIV_STEPS];
  logic [QUO_W-1:0] divq_q [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dv_init[l].dvs = root;
      dv_init[l].rem = {1'b0, side_q[SQRT_END].aw[l][31:1]};
      dv_init[l].quo = '0;
      dv_init[l].nb  = {side_q[SQRT_END].aw[l][0], {(QUO_W-1){1'b0}}};
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      if (j == 0) begin : g_first
        aavr_div_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(dv_init[l]), .q_o(dvc[l][j]));
      end else begin : g_next
        aavr_div_cell u_cell (.clk_i(clk_i), .en_i(en), .d_i(dvc[l][j-1]), .q_o(dvc[l][j]));
      end
    end
  end

  // one more register so the quotients line up with the cordic output
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        divq_q[l] <= dvc[l][DIV_STEPS-1].quo;
      end
    end
  end

  // angle in turns, split into two 32x32 products
  logic [63:0] ph_lo_q, ph_hi_q;
  logic [95:0] prod96;
  logic [31:0] phase;
  logic        fold;
  cordic_t     cin_d, cin_q;
  cordic_t     cdc [CORDIC_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_lo_q <= root * TURN_C[31:0];
      ph_hi_q <= root * TURN_C[63:32];
      cin_q   <= cin_d;
    end
  end

  // fold the second and third quadrant by half a turn, negate at the end
  always_comb begin
    prod96     = {ph_hi_q, 32'd0} + {32'd0, ph_lo_q};
    phase      = prod96[PH_LSB +: 32];
    fold       = phase[31] ^ phase[30];
    cin_d.x    = $signed(XY_W'(CORDIC_GAIN));
    cin_d.y    = '0;
    cin_d.z    = $signed({fold ^ phase[31], fold ^ phase[31], phase[30:0]});
    cin_d.flip = fold;
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    if (j == 0) begin : g_first
      aavr_cordic_cell #(.STEP(j)) u_cell (
        .clk_i(clk_i), .en_i(en), .d_i(cin_q), .q_o(cdc[j])
      );
    end else begin : g_next
      aavr_cordic_cell #(.STEP(j)) u_cell (
        .clk_i(clk_i), .en_i(en), .d_i(cdc[j-1]), .q_o(cdc[j])
      );
    end
  end

  // stage a: signed axis, cross and dot partial products, v*cos
  logic signed [31:0]     k_a [3];
  logic signed [31:0]     v_a [3];
  logic signed [XY_W-1:0] c_a, s_a;
  logic [31:0]            kmag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kmag   = {1'b0, divq_q[i]};
      k_a[i] = side_q[MID_END].wneg[i] ? (32'd0 - kmag) : kmag;
      v_a[i] = $signed(side_q[MID_END].v[i]);
    end
    c_a = cdc[CORDIC_STEPS-1].flip ? -cdc[CORDIC_STEPS-1].x : cdc[CORDIC_STEPS-1].x;
    s_a = cdc[CORDIC_STEPS-1].flip ? -cdc[CORDIC_STEPS-1].y : cdc[CORDIC_STEPS-1].y;
  end

  logic signed [31:0]     k_a_q [3];
  logic signed [63:0]     crp_a_q [3];
  logic signed [63:0]     crn_a_q [3];
  logic signed [63:0]     dotp_a_q [3];
  logic signed [65:0]     vc_a_q [3];
  logic signed [XY_W-1:0] c_a_q, s_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      crp_a_q[0] <= k_a[1] * v_a[2];
      crn_a_q[0] <= k_a[2] * v_a[1];
      crp_a_q[1] <= k_a[2] * v_a[0];
      crn_a_q[1] <= k_a[0] * v_a[2];
      crp_a_q[2] <= k_a[0] * v_a[1];
      crn_a_q[2] <= k_a[1] * v_a[0];
      for (int i = 0; i < 3; i++) begin
        k_a_q[i]    <= k_a[i];
        dotp_a_q[i] <= k_a[i] * v_a[i];
        vc_a_q[i]   <= v_a[i] * c_a;
      end
      c_a_q <= c_a;
      s_a_q <= s_a;
    end
  end

  // stage b: finish cross and dot, round to the input format
  logic [63:0] cr_r [3];
  logic [63:0] dot_r;
  logic [65:0] vc_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_r[i] = crp_a_q[i] - crn_a_q[i] + 64'(RND);
      vc_r[i] = vc_a_q[i] + 66'(RND);
    end
    dot_r = dotp_a_q[0] + dotp_a_q[1] + dotp_a_q[2] + 64'(RND);
  end

  logic signed [33:0]     crr_b_q [3];
  logic signed [33:0]     dotr_b_q;
  logic signed [35:0]     t1_b_q [3];
  logic signed [31:0]     k_b_q [3];
  logic signed [XY_W-1:0] c_b_q, s_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        crr_b_q[i] <= cr_r[i][63:30];
        t1_b_q[i]  <= vc_r[i][65:30];
        k_b_q[i]   <= k_a_q[i];
      end
      dotr_b_q <= dot_r[63:30];
      c_b_q    <= c_a_q;
      s_b_q    <= s_a_q;
    end
  end

  // stage c: cross*sin and dot*(1-cos)
  logic signed [34:0] omc;
  assign omc = 35'sd1073741824 - 35'(c_b_q);

  logic signed [67:0] crs_c_q [3];
  logic signed [68:0] dw_c_q;
  logic signed [35:0] t1_c_q [3];
  logic signed [31:0] k_c_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        crs_c_q[i] <= crr_b_q[i] * s_b_q;
        t1_c_q[i]  <= t1_b_q[i];
        k_c_q[i]   <= k_b_q[i];
      end
      dw_c_q <= dotr_b_q * omc;
    end
  end

  // stage d: round the sine term and the axis weight
  logic [67:0] crs_r [3];
  logic [68:0] dw_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crs_r[i] = crs_c_q[i] + 68'(RND);
    end
    dw_r = dw_c_q + 69'(RND);
  end

  logic signed [37:0] t2_d_q [3];
  logic signed [36:0] w16_d_q;
  logic signed [35:0] t1_d_q [3];
  logic signed [31:0] k_d_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        t2_d_q[i] <= crs_r[i][67:30];
        t1_d_q[i] <= t1_c_q[i];
        k_d_q[i]  <= k_c_q[i];
      end
      w16_d_q <= dw_r[66:30];
    end
  end

  // stage e: axis times weight
  logic signed [68:0] kw_e_q [3];
  logic signed [37:0] t2_e_q [3];
  logic signed [35:0] t1_e_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        kw_e_q[i] <= k_d_q[i] * w16_d_q;
        t2_e_q[i] <= t2_d_q[i];
        t1_e_q[i] <= t1_d_q[i];
      end
    end
  end

  // final sum, zero-angle pass-through and saturation
  logic [68:0]          kw_r [3];
  logic signed [38:0]   t3 [3];
  logic signed [RW-1:0] r_sum [3];
  logic signed [RW-1:0] r_sel [3];
  logic [31:0]          r_out [3];
  logic [2:0]           sat;
  out_t                 res;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      kw_r[i]  = kw_e_q[i] + 69'(RND);
      t3[i]    = kw_r[i][68:30];
      r_sum[i] = RW'(t1_e_q[i]) + RW'(t2_e_q[i]) + RW'(t3[i]);
      r_sel[i] = side_q[LAST].zero ? RW'($signed(side_q[LAST].v[i])) : r_sum[i];
      if (r_sel[i] > $signed(SAT_MAX)) begin
        r_out[i] = SAT_MAX[31:0];
        sat[i]   = 1'b1;
      end else if (r_sel[i] < $signed(SAT_MIN)) begin
        r_out[i] = SAT_MIN[31:0];
        sat[i]   = 1'b1;
      end else begin
        r_out[i] = r_sel[i][31:0];
        sat[i]   = 1'b0;
      end
    end
    res.rot_x    = r_out[0];
    res.rot_y    = r_out[1];
    res.rot_z    = r_out[2];
    res.overflow = |sat;
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_o.ready) begin
        skid_v_q <= 1'b0;
      end
    end else if (vld_q[LAST]) begin
      if (!out_v_q || out_o.ready) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_o.ready) begin
        out_data_q <= skid_data_q;
      end
    end else if (vld_q[LAST]) begin
      if (!out_v_q || out_o.ready) begin
        out_data_q <= res;
      end else begin
        skid_data_q <= res;
      end
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_data_q;
endmodule

[rtl/core/aavr_checker.sv]
// port-level checks of the rotation block, bound to the top level
`timescale 1ns / 1ps
`include "axis_angle_vector_rotation_defines.svh"
module aavr_checker #(
  parameter int WORD_BITS = aavr_pkg::WORD_BITS_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input aavr_pkg::out_t out_data_i
);
  import aavr_pkg::*;

  localparam logic [31:0] MAX_LO = (WORD_BITS > 32) ? 32'hFFFF_FFFF :
                                   32'((64'd1 << (WORD_BITS - 1)) - 64'd1);
  localparam logic [31:0] MIN_LO = (WORD_BITS > 32) ? 32'd0 : ~MAX_LO;

  logic at_bound;
  assign at_bound = (out_data_i.rot_x == MAX_LO) || (out_data_i.rot_x == MIN_LO) ||
                    (out_data_i.rot_y == MAX_LO) || (out_data_i.rot_y == MIN_LO) ||
                    (out_data_i.rot_z == MAX_LO) || (out_data_i.rot_z == MIN_LO);

  // a stalled result holds
  `AAVR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "result changed while stalled")

  // back-pressure only ever comes from a waiting result
  `AAVR_ASSERT_IMP(a_stall_cause, !in_ready_i, out_valid_i, "input stalled with no result waiting")

  // one taken result frees the input side again
  `AAVR_ASSERT_NXT(a_stall_release, !in_ready_i && out_ready_i, in_ready_i, "input stayed stalled after a transfer")

  // an overflow flag comes with a clamped component
  `AAVR_ASSERT_IMP(a_ovf_bound, out_valid_i && out_data_i.overflow, at_bound, "overflow without a saturated component")

  logic unused_in_valid;
  assign unused_in_valid = in_valid_i;
endmodule

bind axis_angle_vector_rotation aavr_checker #(
  .WORD_BITS(WORD_BITS)
) u_aavr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
